### src/ihds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihds_pkg
// Shared types and byte constants for the image header dimension sniffer.
// ----------------------------------------------------------------------------
package ihds_pkg;

  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_D8 = 8'hD8;
  localparam logic [7:0] BYTE_E0 = 8'hE0;
  localparam logic [7:0] BYTE_C0 = 8'hC0;
  localparam logic [7:0] BYTE_C1 = 8'hC1;
  localparam logic [7:0] BYTE_C2 = 8'hC2;
  localparam logic [7:0] BYTE_C3 = 8'hC3;
  localparam logic [7:0] BYTE_C9 = 8'hC9;
  localparam logic [7:0] BYTE_CA = 8'hCA;
  localparam logic [7:0] BYTE_CB = 8'hCB;
  localparam logic [7:0] BYTE_89 = 8'h89;
  localparam logic [7:0] BYTE_1A = 8'h1A;
  localparam logic [7:0] BYTE_0D = 8'h0D;
  localparam logic [7:0] BYTE_0A = 8'h0A;

  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned WINDOW_BYTES = 12;
  localparam int unsigned FIRST_WINDOW_END = 13;

  typedef enum logic [1:0] {
    SCAN_IDLE     = 2'd0,
    SCAN_ACTIVE   = 2'd1,
    SCAN_DONE     = 2'd2,
    SCAN_NOT_JFIF = 2'd3
  } scan_status_t;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_JPEG = 2'd1,
    FMT_GIF  = 2'd2,
    FMT_PNG  = 2'd3
  } image_format_t;

  typedef struct packed {
    logic [HEADER_BYTES-1:0][7:0] header;
    scan_status_t                 status;
    logic                         marker_ok;
    logic [15:0]                  height;
    logic [15:0]                  width;
    logic                         long_enough;
  } sniff_view_t;

  typedef struct packed {
    image_format_t format;
    logic [31:0]   width;
    logic [31:0]   height;
  } sniff_result_t;

endpackage
`default_nettype wire

### src/ihds_window_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihds_window_tracker
// Holds the header bytes, the recent byte window, the position counter and
// the JFIF segment scan, and presents the state as it stands after a byte.
// ----------------------------------------------------------------------------
module ihds_window_tracker #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      step,
  input  wire  [7:0]               data_byte,
  input  wire                      last_byte,
  output ihds_pkg::sniff_view_t    view
);
  import ihds_pkg::*;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  localparam logic [POS_WIDTH-1:0] FIRST_END = POS_WIDTH'(FIRST_WINDOW_END);
  localparam logic [POS_WIDTH-1:0] HDR_LEN = POS_WIDTH'(HEADER_BYTES);

  logic [HEADER_BYTES-1:0][7:0] header;
  logic [HEADER_BYTES-1:0][7:0] header_next;
  logic [WINDOW_BYTES-1:0][7:0] recent;
  logic [WINDOW_BYTES-1:0][7:0] recent_next;
  logic [POS_WIDTH-1:0]         pos;
  logic [POS_WIDTH-1:0]         pos_next;
  logic [POS_WIDTH-1:0]         target;
  logic [POS_WIDTH-1:0]         target_next;
  scan_status_t                 status;
  scan_status_t                 status_next;
  logic                         marker_ok;
  logic                         marker_ok_next;
  logic [15:0]                  height;
  logic [15:0]                  height_next;
  logic [15:0]                  width;
  logic [15:0]                  width_next;

  logic                         pos_sat;
  logic                         hit;
  logic                         jfif;
  logic                         take;
  logic                         frame;
  logic [POS_WIDTH:0]           sum;

  function automatic logic is_frame_marker(input logic [7:0] m);
    return m == BYTE_C0 || m == BYTE_C1 || m == BYTE_C2 || m == BYTE_C3 ||
           m == BYTE_C9 || m == BYTE_CA || m == BYTE_CB;
  endfunction

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      header_next[i] = (pos == POS_WIDTH'(i)) ? data_byte : header[i];
    end
  end

  assign recent_next = {data_byte, recent[WINDOW_BYTES-1:1]};
  assign pos_sat     = (pos == POS_MAX);
  assign hit         = !pos_sat && (pos == target);
  assign pos_next    = pos_sat ? pos : pos + POS_WIDTH'(1);

  assign jfif = header_next[0] == BYTE_FF && header_next[1] == BYTE_D8 &&
                header_next[2] == BYTE_FF && header_next[3] == BYTE_E0 &&
                header_next[6] == 8'h4A && header_next[7] == 8'h46 &&
                header_next[8] == 8'h49 && header_next[9] == 8'h46;

  // The window is the twelve bytes ending with the current one.
  assign frame = is_frame_marker(recent_next[1]);
  assign sum   = {1'b0, target} + (POS_WIDTH+1)'(2) +
                 (POS_WIDTH+1)'({recent_next[2], recent_next[3]});

  always_comb begin
    status_next    = status;
    target_next    = target;
    marker_ok_next = marker_ok;
    height_next    = height;
    width_next     = width;
    take           = 1'b0;
    if (hit) begin
      if (status == SCAN_IDLE) begin
        if (jfif) begin
          take = 1'b1;
        end else begin
          status_next = SCAN_NOT_JFIF;
        end
      end else if (status == SCAN_ACTIVE) begin
        take = 1'b1;
      end
    end
    if (take) begin
      marker_ok_next = (recent_next[0] == BYTE_FF);
      height_next    = {recent_next[5], recent_next[6]};
      width_next     = {recent_next[7], recent_next[8]};
      if (recent_next[0] != BYTE_FF || frame) begin
        status_next = SCAN_DONE;
      end else if (sum >= {1'b0, POS_MAX}) begin
        status_next = SCAN_DONE;
      end else begin
        status_next = SCAN_ACTIVE;
        target_next = sum[POS_WIDTH-1:0];
      end
    end
  end

  assign view.header      = header_next;
  assign view.status      = status_next;
  assign view.marker_ok   = marker_ok_next;
  assign view.height      = height_next;
  assign view.width       = width_next;
  assign view.long_enough = (pos_next >= HDR_LEN);

  always_ff @(posedge clk) begin
    if (step) begin
      header <= header_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      recent    <= '0;
      pos       <= '0;
      target    <= FIRST_END;
      status    <= SCAN_IDLE;
      marker_ok <= 1'b0;
      height    <= '0;
      width     <= '0;
    end else if (step) begin
      recent    <= recent_next;
      pos       <= pos_next;
      target    <= target_next;
      status    <= status_next;
      marker_ok <= marker_ok_next;
      height    <= height_next;
      width     <= width_next;
    end
  end

endmodule
`default_nettype wire

### src/ihds_format_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihds_format_decode
// Recognizes JPEG, GIF and PNG from the header bytes and scan results and
// extracts the image width and height.
// ----------------------------------------------------------------------------
module ihds_format_decode (
  input  wire  ihds_pkg::sniff_view_t   view,
  output ihds_pkg::sniff_result_t       result
);
  import ihds_pkg::*;

  logic [HEADER_BYTES-1:0][7:0] h;
  logic                         from_window;
  logic                         b2_ff;
  logic [15:0]                  jpeg_h;
  logic [15:0]                  jpeg_w;
  logic                         is_jpeg;
  logic                         is_gif;
  logic                         is_png;

  assign h           = view.header;
  assign from_window = (view.status == SCAN_ACTIVE) || (view.status == SCAN_DONE);
  assign b2_ff       = from_window ? view.marker_ok : (h[2] == BYTE_FF);
  assign jpeg_h      = from_window ? view.height : {h[7], h[8]};
  assign jpeg_w      = from_window ? view.width : {h[9], h[10]};

  assign is_jpeg = h[0] == BYTE_FF && h[1] == BYTE_D8 && b2_ff;
  assign is_gif  = h[0] == 8'h47 && h[1] == 8'h49 && h[2] == 8'h46;
  assign is_png  = h[0] == BYTE_89 && h[1] == 8'h50 && h[2] == 8'h4E &&
                   h[3] == 8'h47 && h[4] == BYTE_0D && h[5] == BYTE_0A &&
                   h[6] == BYTE_1A && h[7] == BYTE_0A && h[12] == 8'h49 &&
                   h[13] == 8'h48 && h[14] == 8'h44 && h[15] == 8'h52;

  always_comb begin
    result.format = FMT_NONE;
    result.width  = '0;
    result.height = '0;
    if (view.long_enough) begin
      if (is_jpeg) begin
        result.format = FMT_JPEG;
        result.height = {16'h0000, jpeg_h};
        result.width  = {16'h0000, jpeg_w};
      end else if (is_gif) begin
        result.format = FMT_GIF;
        result.width  = {16'h0000, h[7], h[6]};
        result.height = {16'h0000, h[9], h[8]};
      end else if (is_png) begin
        result.format = FMT_PNG;
        result.width  = {h[16], h[17], h[18], h[19]};
        result.height = {h[20], h[21], h[22], h[23]};
      end
    end
  end

endmodule
`default_nettype wire

### src/image_header_dimension_sniffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_header_dimension_sniffer
// Byte stream image header parser: reports format, width and height of a file.
// The result word is registered; it loads when the last byte leaves the input register.
// Throughput: one byte per cycle, but a last byte waits while the output slot is full.
// The output register lets the next file's bytes enter while a result waits.
// Reset is synchronous; after each result the parser returns to reset state.
// ----------------------------------------------------------------------------
module image_header_dimension_sniffer #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // data_byte[7:0]
  input  wire         s_tlast,   // last_byte
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata    // image_format[1:0], image_width[33:2],
                                 // image_height[65:34], zero fill above
);
  import ihds_pkg::*;

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_last;
  logic          advance;
  logic          slot_free;
  sniff_view_t   view;
  sniff_result_t result;
  sniff_result_t out_result;

  assign slot_free = !m_tvalid || m_tready;
  assign advance   = in_valid && (!in_last || slot_free);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ihds_window_tracker #(
    .POS_WIDTH (POS_WIDTH)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .view      (view)
  );

  ihds_format_decode u_decode (
    .view   (view),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {6'b000000, out_result.height, out_result.width,
                    out_result.format};

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the image header dimension sniffer. Whole files are
// streamed in byte by byte: a directed set of GIF, PNG, JFIF, EXIF, truncated
// and malformed files first, then random files with random pacing on both
// sides. Result words are checked against typed values or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
  import ihds_pkg::*;

  localparam int unsigned POS_WIDTH = 32;
  localparam logic [63:0] POS_LIMIT = (64'd1 << POS_WIDTH) - 64'd1;
  localparam logic [6:0][7:0] SOF_CODES = {BYTE_CB, BYTE_CA, BYTE_C9, BYTE_C3, BYTE_C2,
                                           BYTE_C1, BYTE_C0};

  typedef enum logic [2:0] {
    F_NOISE, F_GIF, F_PNG, F_EXIF, F_JFIF, F_JFIF_BAD
  } file_kind_t;

  typedef struct packed {
    file_kind_t    kind;
    logic [7:0]    len;
    logic [7:0]    mark;
    logic [15:0]   seg0;
    logic [1:0]    napp;
    logic [31:0]   w;
    logic [31:0]   h;
    logic          typed;
    image_format_t fmt;
  } file_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [71:0] m_tdata;

  image_header_dimension_sniffer #(.POS_WIDTH(POS_WIDTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  sniff_result_t pending_results[$];
  logic [7:0]    file_bytes[$];
  file_row_t     plan[19];
  int unsigned   seg1_at;
  int unsigned   fail_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   files_sent = 0;
  int unsigned   words_checked = 0;
  int unsigned   fmt_seen[4] = '{0, 0, 0, 0};
  bit            idle_tx = 1'b0;
  bit            idle_rx = 1'b0;
  bit            rx_armed = 1'b0;
  int unsigned   rx_hold = 0;
  bit            typed_on = 1'b0;
  sniff_result_t typed_r;

  // Predicted parser state.
  logic [7:0]   hdr[HEADER_BYTES];
  logic [7:0]   recent[WINDOW_BYTES];
  logic [63:0]  pos;
  logic [63:0]  win_end;
  scan_status_t scan;
  logic         win_ff;
  logic [15:0]  seen_h;
  logic [15:0]  seen_w;

  function automatic bit is_sof(input logic [7:0] m);
    return m == BYTE_C0 || m == BYTE_C1 || m == BYTE_C2 || m == BYTE_C3 ||
           m == BYTE_C9 || m == BYTE_CA || m == BYTE_CB;
  endfunction

  task automatic clear_sniffer();
    for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'd0;
    for (int i = 0; i < WINDOW_BYTES; i++) recent[i] = 8'd0;
    pos = 64'd0;
    win_end = 64'(FIRST_WINDOW_END);
    scan = SCAN_IDLE;
    win_ff = 1'b0;
    seen_h = 16'd0;
    seen_w = 16'd0;
  endtask

  task automatic scan_window();
    logic [63:0] nxt;
    win_ff = (recent[0] == BYTE_FF);
    seen_h = {recent[5], recent[6]};
    seen_w = {recent[7], recent[8]};
    if (!win_ff || is_sof(recent[1])) begin
      scan = SCAN_DONE;
    end else begin
      nxt = win_end + 64'd2 + {48'd0, recent[2], recent[3]};
      if (nxt >= POS_LIMIT) scan = SCAN_DONE;
      else win_end = nxt;
    end
  endtask

  task automatic sniff_step(input logic [7:0] b, input logic l, output bit got,
                            output sniff_result_t r);
    logic [63:0] idx;
    logic [7:0]  b2, b7, b8, b9, b10;
    idx = pos;
    r = '0;
    r.format = FMT_NONE;
    if (idx < HEADER_BYTES) hdr[idx[4:0]] = b;
    for (int i = 0; i < WINDOW_BYTES - 1; i++) recent[i] = recent[i+1];
    recent[WINDOW_BYTES-1] = b;
    if (idx < POS_LIMIT && idx == win_end) begin
      if (scan == SCAN_IDLE) begin
        if (hdr[0] == BYTE_FF && hdr[1] == BYTE_D8 && hdr[2] == BYTE_FF &&
            hdr[3] == BYTE_E0 && hdr[6] == "J" && hdr[7] == "F" && hdr[8] == "I" &&
            hdr[9] == "F") begin
          scan = SCAN_ACTIVE;
          scan_window();
        end else begin
          scan = SCAN_NOT_JFIF;
        end
      end else if (scan == SCAN_ACTIVE) begin
        scan_window();
      end
    end
    if (pos < POS_LIMIT) pos = pos + 64'd1;
    got = l;
    if (!l) return;
    if (pos >= HEADER_BYTES) begin
      if (scan == SCAN_ACTIVE || scan == SCAN_DONE) begin
        b2 = win_ff ? BYTE_FF : 8'h00;
        b7 = seen_h[15:8];
        b8 = seen_h[7:0];
        b9 = seen_w[15:8];
        b10 = seen_w[7:0];
      end else begin
        b2 = hdr[2];
        b7 = hdr[7];
        b8 = hdr[8];
        b9 = hdr[9];
        b10 = hdr[10];
      end
      if (hdr[0] == BYTE_FF && hdr[1] == BYTE_D8 && b2 == BYTE_FF) begin
        r.format = FMT_JPEG;
        r.height = {16'd0, b7, b8};
        r.width = {16'd0, b9, b10};
      end else if (hdr[0] == "G" && hdr[1] == "I" && hdr[2] == "F") begin
        r.format = FMT_GIF;
        r.width = {16'd0, hdr[7], hdr[6]};
        r.height = {16'd0, hdr[9], hdr[8]};
      end else if (hdr[0] == BYTE_89 && hdr[1] == "P" && hdr[2] == "N" && hdr[3] == "G" &&
                   hdr[4] == BYTE_0D && hdr[5] == BYTE_0A && hdr[6] == BYTE_1A &&
                   hdr[7] == BYTE_0A && hdr[12] == "I" && hdr[13] == "H" &&
                   hdr[14] == "D" && hdr[15] == "R") begin
        r.format = FMT_PNG;
        r.width = {hdr[16], hdr[17], hdr[18], hdr[19]};
        r.height = {hdr[20], hdr[21], hdr[22], hdr[23]};
      end
    end
    clear_sniffer();
  endtask

  task automatic put(input logic [7:0] v);
    file_bytes.insert(file_bytes.size(), v);
  endtask

  task automatic put16(input logic [15:0] v);
    put(v[15:8]);
    put(v[7:0]);
  endtask

  task automatic build_file(input file_row_t row);
    int unsigned pay;
    logic [7:0]  m;
    file_bytes.delete();
    seg1_at = 0;
    case (row.kind)
      F_GIF: begin
        put("G"); put("I"); put("F"); put("8"); put("9"); put("a");
        put(row.w[7:0]); put(row.w[15:8]); put(row.h[7:0]); put(row.h[15:8]);
      end
      F_PNG: begin
        put(BYTE_89); put("P"); put("N"); put("G");
        put(BYTE_0D); put(BYTE_0A); put(BYTE_1A); put(BYTE_0A);
        put16(16'd0); put16(16'd13); put("I"); put("H"); put("D"); put("R");
        put16(row.w[31:16]); put16(row.w[15:0]); put16(row.h[31:16]); put16(row.h[15:0]);
      end
      F_EXIF: begin
        put(BYTE_FF); put(BYTE_D8); put(BYTE_FF); put(8'hE1);
        repeat (3) put(8'($urandom));
        put16(row.h[15:0]); put16(row.w[15:0]);
      end
      F_JFIF, F_JFIF_BAD: begin
        put(BYTE_FF); put(BYTE_D8); put(BYTE_FF); put(BYTE_E0); put16(row.seg0);
        put("J"); put("F"); put("I"); put("F"); put(8'h00);
        pay = (row.seg0 > 16'd7) ? 32'(row.seg0) - 32'd7 : 32'd0;
        if (pay > 64) pay = 64;
        repeat (pay) put(8'($urandom));
        seg1_at = file_bytes.size();
        repeat (row.napp) begin
          m = 8'($urandom);
          if (is_sof(m)) m = 8'hFE;
          pay = $urandom_range(2, 12);
          put(BYTE_FF); put(m); put16(pay[15:0]);
          repeat (pay - 2) put(8'($urandom));
        end
        put(BYTE_FF); put(row.mark); put16(16'd17); put(8'd8);
        put16(row.h[15:0]); put16(row.w[15:0]); put(8'd3);
        repeat (9) put(8'($urandom));
        repeat ($urandom_range(0, 4)) put(8'($urandom));
        if (row.kind == F_JFIF_BAD) file_bytes[seg1_at] = 8'($urandom_range(0, 254));
      end
      default: ;
    endcase
    while (file_bytes.size() < row.len) put(8'($urandom));
    while (row.len != 0 && file_bytes.size() > row.len) m = file_bytes.pop_back();
  endtask

  task automatic push_byte(input logic [7:0] b, input logic l);
    int unsigned   gap;
    bit            got;
    sniff_result_t r;
    gap = idle_tx ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= l;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    sniff_step(b, l, got, r);
    if (got) pending_results.insert(pending_results.size(), typed_on ? typed_r : r);
    @(negedge clk);
  endtask

  task automatic play_file();
    idle_tx = ($urandom_range(0, 3) != 0);
    foreach (file_bytes[i]) push_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  task automatic drain_results();
    if (pending_results.size() != 0) begin
      s_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    if (m_tvalid === 1'b1 && !rx_armed) begin
      rx_armed = 1'b1;
      rx_hold = idle_rx ? $urandom_range(0, 17) : 0;
    end
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (m_tvalid !== 1'b1 && idle_rx) begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sniff_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      rx_armed = 1'b0;
      idle_rx = ($urandom_range(0, 3) != 0);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        words_checked++;
        fmt_seen[e.format]++;
        if (m_tdata[1:0] !== e.format) begin
          $display("%0t: format mismatch, expected %0d, got %0d", $time, e.format,
                   m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[33:2] !== e.width) begin
          $display("%0t: width mismatch, expected %0d, got %0d", $time, e.width,
                   m_tdata[33:2]);
          fail_count++;
        end
        if (m_tdata[65:34] !== e.height) begin
          $display("%0t: height mismatch, expected %0d, got %0d", $time, e.height,
                   m_tdata[65:34]);
          fail_count++;
        end
        if (m_tdata[71:66] !== 6'd0) begin
          $display("%0t: fill bits mismatch, expected 0, got %h", $time, m_tdata[71:66]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    file_row_t row;
    int unsigned pick;
    clear_sniffer();
    // Short files, field extremes, every frame marker, early end and a broken scan.
    plan[0]  = '{F_NOISE,    8'd1,  8'h00,   16'd0,     2'd0, 32'd0,      32'd0,
                 1'b1, FMT_NONE};
    plan[1]  = '{F_NOISE,    8'd23, 8'h00,   16'd0,     2'd0, 32'd0,      32'd0,
                 1'b1, FMT_NONE};
    plan[2]  = '{F_NOISE,    8'd24, 8'h00,   16'd0,     2'd0, 32'd0,      32'd0,
                 1'b0, FMT_NONE};
    plan[3]  = '{F_GIF,      8'd24, 8'h00,   16'd0,     2'd0, 32'd0,      32'd0,
                 1'b1, FMT_GIF};
    plan[4]  = '{F_GIF,      8'd30, 8'h00,   16'd0,     2'd0, 32'hFFFF,   32'hFFFF,
                 1'b1, FMT_GIF};
    plan[5]  = '{F_PNG,      8'd24, 8'h00,   16'd0,     2'd0, 32'd0,      32'd0,
                 1'b1, FMT_PNG};
    plan[6]  = '{F_PNG,      8'd24, 8'h00,   16'd0,     2'd0, 32'hFFFFFFFF, 32'hFFFFFFFF,
                 1'b1, FMT_PNG};
    plan[7]  = '{F_EXIF,     8'd24, 8'h00,   16'd0,     2'd0, 32'hFFFF,   32'd0,
                 1'b1, FMT_JPEG};
    plan[8]  = '{F_JFIF,     8'd0,  BYTE_C0, 16'd16,    2'd0, 32'd1,      32'hFFFF,
                 1'b0, FMT_NONE};
    plan[9]  = '{F_JFIF,     8'd0,  BYTE_C1, 16'd16,    2'd1, 32'd640,    32'd480,
                 1'b0, FMT_NONE};
    plan[10] = '{F_JFIF,     8'd0,  BYTE_C2, 16'd16,    2'd2, 32'h1234,   32'h8001,
                 1'b0, FMT_NONE};
    plan[11] = '{F_JFIF,     8'd0,  BYTE_C3, 16'd20,    2'd3, 32'hABCD,   32'd7,
                 1'b0, FMT_NONE};
    plan[12] = '{F_JFIF,     8'd0,  BYTE_C9, 16'd16,    2'd0, 32'd3,      32'd5,
                 1'b0, FMT_NONE};
    plan[13] = '{F_JFIF,     8'd0,  BYTE_CA, 16'd9,     2'd1, 32'h0100,   32'h0200,
                 1'b0, FMT_NONE};
    plan[14] = '{F_JFIF,     8'd0,  BYTE_CB, 16'd16,    2'd0, 32'hFFFF,   32'd0,
                 1'b0, FMT_NONE};
    plan[15] = '{F_JFIF_BAD, 8'd0,  BYTE_C0, 16'd16,    2'd0, 32'd0,      32'd0,
                 1'b1, FMT_NONE};
    plan[16] = '{F_JFIF,     8'd30, BYTE_C0, 16'd16,    2'd1, 32'd9,      32'd9,
                 1'b0, FMT_NONE};
    plan[17] = '{F_JFIF,     8'd60, BYTE_C0, 16'hFFFF,  2'd0, 32'd9,      32'd9,
                 1'b0, FMT_NONE};
    plan[18] = '{F_JFIF,     8'd0,  BYTE_C2, 16'd2,     2'd2, 32'd77,     32'd66,
                 1'b0, FMT_NONE};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      build_file(plan[k]);
      typed_on = plan[k].typed;
      typed_r.format = plan[k].fmt;
      typed_r.width = plan[k].w;
      typed_r.height = plan[k].h;
      play_file();
    end
    typed_on = 1'b0;
    drain_results();

    while (bytes_sent < 1250) begin
      pick = $urandom_range(0, 99);
      row = '0;
      row.w = $urandom;
      row.h = $urandom;
      row.mark = SOF_CODES[$urandom_range(0, 6)];
      row.seg0 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(2, 24));
      row.napp = 2'($urandom_range(0, 3));
      if (pick < 40) begin
        row.kind = F_JFIF;
        row.len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 60)) : 8'd0;
      end else if (pick < 50) begin
        row.kind = F_EXIF;
        row.len = 8'($urandom_range(24, 36));
      end else if (pick < 62) begin
        row.kind = F_GIF;
        row.len = 8'($urandom_range(24, 36));
      end else if (pick < 74) begin
        row.kind = F_PNG;
        row.len = 8'($urandom_range(24, 36));
      end else if (pick < 82) begin
        row.kind = F_JFIF_BAD;
        row.len = 8'd0;
      end else begin
        row.kind = F_NOISE;
        row.len = 8'($urandom_range(1, 40));
      end
      build_file(row);
      if ($urandom_range(0, 5) == 0)
        file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
      play_file();
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d files in %0d bytes and checked %0d result words.", files_sent,
             bytes_sent, words_checked);
    $display("Formats seen: %0d none, %0d JPEG, %0d GIF, %0d PNG.", fmt_seen[FMT_NONE],
             fmt_seen[FMT_JPEG], fmt_seen[FMT_GIF], fmt_seen[FMT_PNG]);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
src/ihds_pkg.sv
src/ihds_window_tracker.sv
src/ihds_format_decode.sv
src/image_header_dimension_sniffer.sv
tb/tb.sv
